>>> hdl/pixel_hsv_shift_top_macros.svh
// Assertion macros shared by the pixel HSV shift RTL.
`ifndef PIXEL_HSV_SHIFT_TOP_MACROS_SVH
`define PIXEL_HSV_SHIFT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked on every clock outside reset
`define PHS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |-> cons) else $error(msg);
// Next-cycle implication checked on every clock outside reset
`define PHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define PHS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/phs_pkg.sv
// Shared types and constants of the pixel HSV shift block.
package phs_pkg;

  localparam int unsigned GAIN_BITS = 17;
  localparam int unsigned QUO_BITS  = 17;
  localparam int unsigned ADDR_BITS = 4;

  localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 17'd65536;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_HUE_OFFSET = 2'd0;
  localparam logic [1:0] REG_SAT_GAIN   = 2'd1;
  localparam logic [1:0] REG_VAL_GAIN   = 2'd2;

  // Hue segment multiplier of delta
  localparam logic [1:0] SEG_ZERO = 2'd0;
  localparam logic [1:0] SEG_TWO  = 2'd1;
  localparam logic [1:0] SEG_FOUR = 2'd2;
  localparam logic [1:0] SEG_SIX  = 2'd3;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic signed [15:0]    hue_offset;
    logic [GAIN_BITS-1:0]  saturation_gain;
    logic [GAIN_BITS-1:0]  value_gain;
  } cfg_t;

endpackage

>>> hdl/phs_cfg_regs.sv
// APB register file holding hue offset and the two gains.
module phs_cfg_regs import phs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic [15:0]          hue_r;
  logic [GAIN_BITS-1:0] sat_r;
  logic [GAIN_BITS-1:0] val_r;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r <= '0;
      sat_r <= UNITY_GAIN;
      val_r <= UNITY_GAIN;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_HUE_OFFSET: hue_r <= pwdata[15:0];
        REG_SAT_GAIN:   sat_r <= pwdata[GAIN_BITS-1:0];
        REG_VAL_GAIN:   val_r <= pwdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_HUE_OFFSET: prdata = {16'd0, hue_r};
      REG_SAT_GAIN:   prdata = {{(32-GAIN_BITS){1'b0}}, sat_r};
      REG_VAL_GAIN:   prdata = {{(32-GAIN_BITS){1'b0}}, val_r};
      default:        prdata = '0;
    endcase
  end

  assign cfg.hue_offset      = $signed(hue_r);
  assign cfg.saturation_gain = sat_r;
  assign cfg.value_gain      = val_r;

endmodule

>>> hdl/phs_front.sv
// Front stages: max, min, delta, hue numerator and divider operands.
module phs_front import phs_pkg::*; #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic [CHANNEL_BITS+16:0] sat_num,
  output logic [CHANNEL_BITS-1:0]  sat_den,
  output logic [CHANNEL_BITS+18:0] hue_num,
  output logic [CHANNEL_BITS+2:0]  hue_den,
  output logic                     grey
);

  localparam int W  = CHANNEL_BITS;
  localparam int NW = W + 3;

  logic [W-1:0]  mx, mn;
  logic [NW-1:0] diff;
  logic [1:0]    seg;

  logic [W-1:0]  mx1_r, mn1_r;
  logic [NW-1:0] diff1_r;
  logic [1:0]    seg1_r;

  logic [W-1:0]  dl;
  logic [NW-1:0] dl_x, segd, num;

  logic [W-1:0]  mx2_r, dl2_r;
  logic [NW-1:0] num2_r;

  // Pick the largest channel, ties go red then green
  always_comb begin
    if (red >= green && red >= blue) begin
      mx   = red;
      diff = NW'(green) - NW'(blue);
      seg  = (green < blue) ? SEG_SIX : SEG_ZERO;
    end else if (green >= blue) begin
      mx   = green;
      diff = NW'(blue) - NW'(red);
      seg  = SEG_TWO;
    end else begin
      mx   = blue;
      diff = NW'(red) - NW'(green);
      seg  = SEG_FOUR;
    end
    mn = (red < green) ? red : green;
    if (blue < mn) mn = blue;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1_r   <= mx;
      mn1_r   <= mn;
      diff1_r <= diff;
      seg1_r  <= seg;
    end
  end

  // Delta and hue numerator
  assign dl   = mx1_r - mn1_r;
  assign dl_x = NW'(dl);

  always_comb begin
    case (seg1_r)
      SEG_ZERO: segd = '0;
      SEG_TWO:  segd = dl_x << 1;
      SEG_FOUR: segd = dl_x << 2;
      SEG_SIX:  segd = (dl_x << 2) + (dl_x << 1);
      default:  segd = '0;
    endcase
  end

  assign num = segd + diff1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mx2_r  <= mx1_r;
      dl2_r  <= dl;
      num2_r <= num;
    end
  end

  // Divider operands with rounding terms folded in
  always_ff @(posedge clk) begin
    if (en) begin
      sat_num <= {dl2_r, 16'd0} + (W+17)'(mx2_r >> 1);
      sat_den <= mx2_r;
      hue_num <= {num2_r, 16'd0} + (W+19)'({dl2_r, 1'b0}) + (W+19)'(dl2_r);
      hue_den <= NW'({dl2_r, 2'b0}) + NW'({dl2_r, 1'b0});
      grey    <= (dl2_r == '0);
    end
  end

endmodule

>>> hdl/phs_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module phs_div_pipe #(
  parameter int NW = 33,
  parameter int DW = 16,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in = DW'(num >> QW);
      assign low_in = num[QW-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // Shift in one dividend bit, subtract when it fits
    assign trial = {rem_in, low_in[QW-1-k]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
        low_r[k] <= low_in;
        den_r[k] <= den_in;
        quo_r[k] <= {quo_in[QW-2:0], ~diff[DW]};
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

>>> hdl/phs_back.sv
// Back stages: hue rotation, gains and HSV to RGB conversion.
module phs_back import phs_pkg::*; #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  cfg_t                    cfg,
  input  logic [QUO_BITS-1:0]     sat_q,
  input  logic [QUO_BITS-1:0]     hue_q,
  input  logic [CHANNEL_BITS-1:0] vmax,
  input  logic                    grey,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue
);

  localparam int W   = CHANNEL_BITS;
  localparam int SPW = 2 * GAIN_BITS;
  localparam int VPW = W + GAIN_BITS;
  localparam int V2W = W + 1;
  localparam int CSW = V2W + GAIN_BITS;
  localparam int XPW = CSW + GAIN_BITS;
  localparam int CHW = XPW - 32;

  logic [15:0]          h2_r;
  logic [SPW-1:0]       sp_r;
  logic [VPW-1:0]       vp_r;

  logic [SPW-1:0]       s_rnd;
  logic [18:0]          hp;
  logic [GAIN_BITS-1:0] s2_r, gp3_r;
  logic [V2W-1:0]       v2_r, v2c_r, v2d_r;
  logic [2:0]           sec_r, secc_r, secd_r;

  logic [CSW-1:0]       cs_r;
  logic [XPW-1:0]       xp_r, mp_r;

  logic [XPW-1:0]       base;
  logic [W-1:0]         ch_c, ch_x, ch_m;

  // Rotate hue, apply both gains
  always_ff @(posedge clk) begin
    if (en) begin
      h2_r <= (grey ? 16'd0 : hue_q[15:0]) + $unsigned(cfg.hue_offset);
      sp_r <= SPW'(grey ? '0 : sat_q) * SPW'(cfg.saturation_gain);
      vp_r <= VPW'(vmax) * VPW'(cfg.value_gain);
    end
  end

  // Round, clamp saturation, split hue into sector and fraction
  assign s_rnd = (sp_r + SPW'(32768)) >> 16;
  assign hp    = {1'b0, h2_r, 2'b0} + {2'b0, h2_r, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r  <= (s_rnd > SPW'(UNITY_GAIN)) ? UNITY_GAIN : s_rnd[GAIN_BITS-1:0];
      v2_r  <= V2W'((vp_r + VPW'(32768)) >> 16);
      sec_r <= hp[18:16];
      gp3_r <= hp[16] ? {1'b0, hp[15:0]} : UNITY_GAIN - {1'b0, hp[15:0]};
    end
  end

  // Chroma, then fractional chroma term
  always_ff @(posedge clk) begin
    if (en) begin
      cs_r   <= CSW'(v2_r) * CSW'(s2_r);
      v2c_r  <= v2_r;
      secc_r <= sec_r;
    end
  end

  logic [GAIN_BITS-1:0] gpc_r;
  always_ff @(posedge clk) begin
    if (en) begin
      gpc_r <= gp3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r   <= XPW'(cs_r) * XPW'(gpc_r);
      mp_r   <= XPW'(cs_r) << 16;
      v2d_r  <= v2c_r;
      secd_r <= secc_r;
    end
  end

  // Round a Q32 channel down and clamp to full scale
  function automatic logic [W-1:0] to_chan(input logic [XPW-1:0] q);
    logic [CHW-1:0] w;
    w = q[XPW-1:32];
    if (w > CHW'({W{1'b1}})) to_chan = {W{1'b1}};
    else                     to_chan = w[W-1:0];
  endfunction

  assign base = (XPW'(v2d_r) << 32) + (XPW'(1) << 31);
  assign ch_c = (v2d_r > V2W'({W{1'b1}})) ? {W{1'b1}} : v2d_r[W-1:0];
  assign ch_x = to_chan(base - xp_r);
  assign ch_m = to_chan(base - mp_r);

  // Route the three terms by sector
  always_comb begin
    case (secd_r)
      3'd0:    begin red = ch_c; green = ch_x; blue = ch_m; end
      3'd1:    begin red = ch_x; green = ch_c; blue = ch_m; end
      3'd2:    begin red = ch_m; green = ch_c; blue = ch_x; end
      3'd3:    begin red = ch_m; green = ch_x; blue = ch_c; end
      3'd4:    begin red = ch_x; green = ch_m; blue = ch_c; end
      default: begin red = ch_c; green = ch_m; blue = ch_x; end
    endcase
  end

endmodule

>>> hdl/pixel_hsv_shift_top.sv
// Top level of the pixel HSV shift block: pipeline control and output skid.
//
//   port group   direction   handshake               word
//   in_*         in          in_valid / in_ready     pix_in_t (red, green, blue)
//   out_*        out         out_valid / out_ready   pix_out_t (red, green, blue)
//   p*           in          psel, penable, pready   32-bit register write / read
//
// One pixel per clock sustained while the output is not stalled.
// Depth is set by the two 17-stage restoring dividers (saturation, hue).
// Reset loads hue offset 0 and unity gains; no clearing pass is needed.
// A stalled output parks one word in a skid register; the pipeline then holds.
`include "pixel_hsv_shift_top_macros.svh"

module pixel_hsv_shift_top import phs_pkg::*; #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pix_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pix_out_t             out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int W    = CHANNEL_BITS;
  localparam int FRONT = 3;
  localparam int BACK  = 4;
  localparam int LAT   = FRONT + QUO_BITS + BACK;

  cfg_t cfg;

  logic                en;
  logic [LAT-1:0]      vld_r;
  pix_out_t            raw_r [LAT];
  logic [W-1:0]        mx_r  [QUO_BITS];
  logic                grey_r [QUO_BITS];

  logic [W-1:0]        red_m, green_m, blue_m;
  logic [W+16:0]       sat_num;
  logic [W-1:0]        sat_den;
  logic [W+18:0]       hue_num;
  logic [W+2:0]        hue_den;
  logic                grey;
  logic [QUO_BITS-1:0] sat_q, hue_q;
  logic [W-1:0]        red_c, green_c, blue_c;

  logic                bypass;
  logic                fin_vld;
  pix_out_t            fin_data;
  logic                out_valid_r, skid_valid_r;
  pix_out_t            out_data_r, skid_data_r;

  phs_cfg_regs u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Drop channel bits above the configured width
  assign red_m   = W'(in_data.red_in);
  assign green_m = W'(in_data.green_in);
  assign blue_m  = W'(in_data.blue_in);

  // Whole pipeline advances while the skid register is empty
  assign en       = !skid_valid_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Carry the masked input word for the pass-through case
  always_ff @(posedge clk) begin
    if (en) begin
      raw_r[0] <= '{red_out: 16'(red_m), green_out: 16'(green_m), blue_out: 16'(blue_m)};
      for (int i = 1; i < LAT; i++) raw_r[i] <= raw_r[i-1];
    end
  end

  phs_front #(.CHANNEL_BITS(W)) u_front (
    .clk, .en, .red(red_m), .green(green_m), .blue(blue_m),
    .sat_num, .sat_den, .hue_num, .hue_den, .grey
  );

  phs_div_pipe #(.NW(W+17), .DW(W), .QW(QUO_BITS)) u_div_sat (
    .clk, .en, .num(sat_num), .den(sat_den), .quo(sat_q)
  );

  phs_div_pipe #(.NW(W+19), .DW(W+3), .QW(QUO_BITS)) u_div_hue (
    .clk, .en, .num(hue_num), .den(hue_den), .quo(hue_q)
  );

  // Advance max and grey flag alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r[0]   <= sat_den;
      grey_r[0] <= grey;
      for (int i = 1; i < QUO_BITS; i++) begin
        mx_r[i]   <= mx_r[i-1];
        grey_r[i] <= grey_r[i-1];
      end
    end
  end

  phs_back #(.CHANNEL_BITS(W)) u_back (
    .clk, .en, .cfg, .sat_q, .hue_q,
    .vmax(mx_r[QUO_BITS-1]), .grey(grey_r[QUO_BITS-1]),
    .red(red_c), .green(green_c), .blue(blue_c)
  );

  // Pick pass-through or converted word
  assign bypass  = (cfg.hue_offset == 16'sd0) && (cfg.saturation_gain == UNITY_GAIN)
                && (cfg.value_gain == UNITY_GAIN);
  assign fin_vld = vld_r[LAT-1] && en;
  assign fin_data = bypass ? raw_r[LAT-1]
                  : pix_out_t'{red_out: 16'(red_c), green_out: 16'(green_c),
                               blue_out: 16'(blue_c)};

  // Output register with one-word skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      out_valid_r  <= skid_valid_r || fin_vld;
      skid_valid_r <= 1'b0;
    end else if (fin_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : fin_data;
    end else if (fin_vld) begin
      skid_data_r <= fin_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PHS_ASSERT_SAME(a_skid_needs_out, clk, rst_n, skid_valid_r, out_valid_r, "skid word without output word")
  `PHS_ASSERT_NEXT(a_skid_freezes, clk, rst_n, skid_valid_r, $stable(vld_r), "pipeline moved while skid full")
  `PHS_ASSERT_NEXT(a_stall_to_skid, clk, rst_n, out_valid_r && !out_ready && fin_vld, skid_valid_r, "word lost on stall")

endmodule
